// ----- hw/rtl/tcw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, constants and tables for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int unsigned COLUMNS   = 80;
  localparam int unsigned ROWS      = 25;
  localparam int unsigned TAB_WIDTH = 4;
  localparam int unsigned CELLS     = COLUMNS * ROWS;

  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned RIDX_W = $clog2(ROWS);
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned POS_W  = 11;

  localparam logic [1:0] ACT_PUT_CHAR  = 2'd0;
  localparam logic [1:0] ACT_PUT_CELL  = 2'd1;
  localparam logic [1:0] ACT_READ_CELL = 2'd2;

  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  localparam logic [15:0] BLANK_CELL       = 16'h0720;
  localparam logic [7:0]  TEXT_COLOR_RESET = 8'h07;
  localparam logic        REG_TEXT_COLOR   = 1'b0;

  typedef enum logic [2:0] {
    CMD_PRINT,
    CMD_NEWLINE,
    CMD_TAB,
    CMD_BACKSPACE,
    CMD_PUT,
    CMD_READ,
    CMD_NONE
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0]       action;
    logic [7:0]       char_code;
    logic [7:0]       cell_color;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0] cursor_position;
    logic [15:0]      cell_data;
  } result_t;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [7:0]       char_code;
    logic [7:0]       cell_color;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
  } cmd_t;

  typedef logic [CNT_W-1:0] tab_span_t [2**COL_W];

  function automatic tab_span_t build_tab_span();
    tab_span_t t;
    for (int i = 0; i < 2**COL_W; i++) begin
      t[i] = CNT_W'(TAB_WIDTH - (i % TAB_WIDTH));
    end
    return t;
  endfunction

  localparam tab_span_t TAB_SPAN = build_tab_span();

endpackage

// ----- hw/rtl/tcw_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/tcw_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_front
// Classifies incoming items into commands and queues them for the back end.
// ----------------------------------------------------------------------------
module tcw_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  tcw_pkg::item_t  item_i,
  output logic            cmd_valid_o,
  output tcw_pkg::cmd_t   cmd_o,
  input  logic            cmd_pop_i
);

  tcw_pkg::cmd_t slot_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          push;
  logic          in_range;
  tcw_pkg::cmd_t cmd_new;

  assign in_range = (32'(item_i.column) < tcw_pkg::COLUMNS) &&
                    (32'(item_i.row) < tcw_pkg::ROWS);

  always_comb begin
    cmd_new.char_code  = item_i.char_code;
    cmd_new.cell_color = item_i.cell_color;
    cmd_new.column     = item_i.column;
    cmd_new.row        = item_i.row;
    case (item_i.action)
      tcw_pkg::ACT_PUT_CHAR: begin
        case (item_i.char_code)
          tcw_pkg::CH_NEWLINE:   cmd_new.kind = tcw_pkg::CMD_NEWLINE;
          tcw_pkg::CH_TAB:       cmd_new.kind = tcw_pkg::CMD_TAB;
          tcw_pkg::CH_BACKSPACE: cmd_new.kind = tcw_pkg::CMD_BACKSPACE;
          default:               cmd_new.kind = tcw_pkg::CMD_PRINT;
        endcase
      end
      tcw_pkg::ACT_PUT_CELL:  cmd_new.kind = in_range ? tcw_pkg::CMD_PUT : tcw_pkg::CMD_NONE;
      tcw_pkg::ACT_READ_CELL: cmd_new.kind = in_range ? tcw_pkg::CMD_READ : tcw_pkg::CMD_NONE;
      default:                cmd_new.kind = tcw_pkg::CMD_NONE;
    endcase
  end

  assign busy        = (count_q == 2'd2);
  assign push        = start && !busy;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ----- hw/rtl/tcw_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_back
// Carries out queued commands on the screen store and cursor, and issues
// one result per command. Rows are kept in a ring with per-row valid bits.
// ----------------------------------------------------------------------------
module tcw_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  tcw_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  input  logic [7:0]       text_color_i,
  output logic             done_o,
  output tcw_pkg::result_t result_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WRITE = 3'd1;
  localparam logic [2:0] S_FILL  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam int unsigned CW = tcw_pkg::COL_W;
  localparam int unsigned RW = tcw_pkg::ROW_W;
  localparam int unsigned IW = tcw_pkg::RIDX_W;
  localparam int unsigned AW = tcw_pkg::ADDR_W;

  logic [2:0]               state_q, state_d;
  tcw_pkg::cmd_kind_e       op_q, op_d;
  logic [CW-1:0]            tgt_col_q, tgt_col_d;
  logic [RW-1:0]            tgt_row_q, tgt_row_d;
  logic [15:0]              cell_q, cell_d;
  logic [tcw_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [CW-1:0]            cur_col_q, cur_col_d;
  logic [RW-1:0]            cur_row_q, cur_row_d;
  logic [IW-1:0]            top_q, top_d;
  logic [tcw_pkg::ROWS-1:0] valid_q, valid_d;
  logic [CW-1:0]            fill_col_q, fill_col_d;
  logic                     done_q;
  tcw_pkg::result_t         result_q;

  logic                     use_cur;
  logic [RW-1:0]            arow;
  logic [CW-1:0]            acol;
  logic [IW:0]              phys_sum;
  logic [IW-1:0]            phys;
  logic                     row_valid;
  logic [AW-1:0]            mem_addr;
  logic                     mem_we, mem_re;
  logic [15:0]              mem_wdata, mem_rdata;

  logic [CW:0]              col_inc;
  logic                     force_wrap;
  logic [CW-1:0]            adv_col;
  logic [RW-1:0]            adv_row;
  logic                     adv_scroll;
  logic [CW:0]              tab_end;
  logic [tcw_pkg::CNT_W-1:0] tab_span;
  logic [11:0]              pos_full;

  assign use_cur = (op_q == tcw_pkg::CMD_PRINT) || (op_q == tcw_pkg::CMD_TAB) ||
                   (op_q == tcw_pkg::CMD_BACKSPACE);
  assign arow    = use_cur ? cur_row_q : tgt_row_q;
  assign acol    = (state_q == S_FILL) ? fill_col_q : (use_cur ? cur_col_q : tgt_col_q);

  assign phys_sum  = {1'b0, arow[IW-1:0]} + {1'b0, top_q};
  assign phys      = (32'(phys_sum) >= tcw_pkg::ROWS) ?
                     IW'(32'(phys_sum) - tcw_pkg::ROWS) : phys_sum[IW-1:0];
  assign row_valid = valid_q[phys];
  assign mem_addr  = AW'(AW'(phys) * AW'(tcw_pkg::COLUMNS)) + AW'(acol);

  assign col_inc    = {1'b0, cur_col_q} + (CW+1)'(1);
  assign force_wrap = (state_q == S_IDLE);
  assign tab_span   = tcw_pkg::TAB_SPAN[cur_col_q];
  assign tab_end    = {1'b0, cur_col_q} + (CW+1)'(tab_span);

  always_comb begin
    adv_scroll = 1'b0;
    adv_col    = col_inc[CW-1:0];
    adv_row    = cur_row_q;
    if (force_wrap || (32'(col_inc) == tcw_pkg::COLUMNS)) begin
      adv_col = '0;
      if (32'(cur_row_q) == tcw_pkg::ROWS - 1) begin
        adv_scroll = 1'b1;
      end else begin
        adv_row = cur_row_q + RW'(1);
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    tgt_col_d  = tgt_col_q;
    tgt_row_d  = tgt_row_q;
    cell_d     = cell_q;
    cnt_d      = cnt_q;
    cur_col_d  = cur_col_q;
    cur_row_d  = cur_row_q;
    top_d      = top_q;
    valid_d    = valid_q;
    fill_col_d = fill_col_q;
    cmd_pop_o  = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_wdata  = cell_q;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          op_d      = cmd_i.kind;
          tgt_col_d = cmd_i.column;
          tgt_row_d = cmd_i.row;
          case (cmd_i.kind)
            tcw_pkg::CMD_PRINT: begin
              cell_d  = {text_color_i, cmd_i.char_code};
              state_d = S_WRITE;
            end
            tcw_pkg::CMD_NEWLINE: begin
              cur_col_d = adv_col;
              cur_row_d = adv_row;
              if (adv_scroll) begin
                top_d          = (32'(top_q) == tcw_pkg::ROWS - 1) ? '0 : top_q + IW'(1);
                valid_d[top_q] = 1'b0;
              end
              state_d = S_DONE;
            end
            tcw_pkg::CMD_TAB: begin
              cell_d = {text_color_i, tcw_pkg::CH_SPACE};
              cnt_d  = tab_span;
              if (32'(tab_end) < tcw_pkg::COLUMNS) begin
                state_d = S_WRITE;
              end else begin
                state_d = S_DONE;
              end
            end
            tcw_pkg::CMD_BACKSPACE: begin
              cell_d = {text_color_i, tcw_pkg::CH_SPACE};
              if (cur_col_q != '0) begin
                cur_col_d = cur_col_q - CW'(1);
                state_d   = S_WRITE;
              end else if (cur_row_q != '0) begin
                cur_row_d = cur_row_q - RW'(1);
                cur_col_d = CW'(tcw_pkg::COLUMNS - 1);
                state_d   = S_WALK;
              end else begin
                state_d = S_DONE;
              end
            end
            tcw_pkg::CMD_PUT: begin
              cell_d  = {cmd_i.cell_color, cmd_i.char_code};
              state_d = S_WRITE;
            end
            tcw_pkg::CMD_READ: state_d = S_READ;
            default:           state_d = S_DONE;
          endcase
        end
      end
      S_WRITE: begin
        if (!row_valid) begin
          fill_col_d = '0;
          state_d    = S_FILL;
        end else begin
          mem_we = 1'b1;
          case (op_q)
            tcw_pkg::CMD_PRINT: begin
              cur_col_d = adv_col;
              cur_row_d = adv_row;
              if (adv_scroll) begin
                top_d          = (32'(top_q) == tcw_pkg::ROWS - 1) ? '0 : top_q + IW'(1);
                valid_d[top_q] = 1'b0;
              end
              state_d = S_DONE;
            end
            tcw_pkg::CMD_TAB: begin
              cur_col_d = cur_col_q + CW'(1);
              cnt_d     = cnt_q - tcw_pkg::CNT_W'(1);
              if (cnt_q == tcw_pkg::CNT_W'(1)) begin
                state_d = S_DONE;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_FILL: begin
        mem_we     = 1'b1;
        mem_wdata  = tcw_pkg::BLANK_CELL;
        fill_col_d = fill_col_q + CW'(1);
        if (32'(fill_col_q) == tcw_pkg::COLUMNS - 1) begin
          valid_d[phys] = 1'b1;
          state_d       = S_WRITE;
        end
      end
      S_WALK: begin
        if (cur_col_q == '0) begin
          state_d = S_DONE;
        end else if (!row_valid) begin
          cur_col_d = '0;
          state_d   = S_DONE;
        end else begin
          mem_re  = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (mem_rdata[7:0] == tcw_pkg::CH_SPACE) begin
          cur_col_d = cur_col_q - CW'(1);
          state_d   = S_WALK;
        end else begin
          if (32'(cur_col_q) < tcw_pkg::COLUMNS - 1) begin
            cur_col_d = cur_col_q + CW'(1);
          end
          state_d = S_DONE;
        end
      end
      S_READ: begin
        mem_re  = 1'b1;
        state_d = S_DONE;
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign pos_full = 12'(12'(cur_row_q) * 12'(tcw_pkg::COLUMNS)) + 12'(cur_col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= tcw_pkg::CMD_NONE;
      cur_col_q <= '0;
      cur_row_q <= '0;
      top_q     <= '0;
      valid_q   <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      top_q     <= top_d;
      valid_q   <= valid_d;
      done_q    <= (state_q == S_DONE);
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_col_q  <= tgt_col_d;
    tgt_row_q  <= tgt_row_d;
    cell_q     <= cell_d;
    cnt_q      <= cnt_d;
    fill_col_q <= fill_col_d;
    if (state_q == S_DONE) begin
      result_q.cursor_position <= pos_full[tcw_pkg::POS_W-1:0];
      if (op_q == tcw_pkg::CMD_READ) begin
        result_q.cell_data <= row_valid ? mem_rdata : tcw_pkg::BLANK_CELL;
      end else begin
        result_q.cell_data <= '0;
      end
    end
  end

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (tcw_pkg::CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ----- hw/rtl/text_console_writer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine: screen store of 16-bit cells and a cursor.
//
//   port group        direction  handshake
//   item_i            in         start / busy
//   result_o          out        done_o strobe, one cycle
//   APB register      in/out     psel, penable, pwrite, pready
//
// A plain character or a cell put passes the write and done states before its
// result is registered, a read the read state. A tab writes spaces up to the
// next tab stop if it lies inside the row. The first write into a row since
// reset or since it scrolled in blanks that row first. A backspace at column
// zero walks the row above, a read and a check state per cell. Scrolling
// rotates a row pointer. No clearing pass after reset. A two-entry queue
// takes new items while a command runs; the receiver cannot stall.
// ----------------------------------------------------------------------------
module text_console_writer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  tcw_pkg::item_t   item_i,
  output logic             done_o,
  output tcw_pkg::result_t result_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic          cmd_valid;
  logic          cmd_pop;
  tcw_pkg::cmd_t cmd;
  logic [7:0]    text_color_q, text_color_d;

  assign pready = 1'b1;

  always_comb begin
    text_color_d = text_color_q;
    if (psel && penable && pwrite && (paddr[2] == tcw_pkg::REG_TEXT_COLOR)) begin
      text_color_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= tcw_pkg::TEXT_COLOR_RESET;
    end else begin
      text_color_q <= text_color_d;
    end
  end

  assign prdata = (paddr[2] == tcw_pkg::REG_TEXT_COLOR) ? {24'd0, text_color_q} : 32'd0;

  tcw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  tcw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .text_color_i (text_color_q),
    .done_o       (done_o),
    .result_o     (result_o)
  );

endmodule
